// ----- rtl/assert_macros.svh -----
// Assertion helpers, all clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/salc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int ADDR_PORT_W = 32;
  localparam int OFFSET_W    = 5;
  localparam int INDEX_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int WAY_OUT_W   = 2;
  localparam int CNT_W       = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/salc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/set_assoc_lru_cache_lookup_core.sv -----
// Set-associative cache lookup with LRU replacement. Each address transfer
// is split into offset, set index and tag per offset_bits / index_bits
// (index_bits saturates at log2 of SETS); the set's WAYS ways are compared
// in one row of a single set memory (valid, tag, rank per way). A hit makes
// the way most recent; a miss fills the lowest invalid way, else the LRU
// way. Each item has two steps: the set memory read, then a step that
// updates ranks, writes the row back and loads the result register; a new
// address is taken only after the lookup is done. The result register
// lets the next address be taken while a result waits; the lookup then
// holds until the result is taken. After reset the set memory is cleared
// one set per cycle, with in_ready low; configuration writes are taken
// throughout. Hit and miss totals saturate at all ones.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module set_assoc_lru_cache_lookup_core
  import salc_pkg::*;
#(
  parameter int WAYS      = 4,
  parameter int SETS      = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_PORT_W-1:0] address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [WAY_OUT_W-1:0]  way,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total
);

  localparam int AW    = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
  localparam int TAG_W = AW;
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WW    = RW;
  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int KMAX  = $clog2(SETS + 1) - 1;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [RW-1:0]    rank;
  } line_t;

  localparam int ROW_W = WAYS * $bits(line_t);

  // configuration
  logic [OFFSET_W-1:0] offset_bits;
  logic [INDEX_W-1:0]  index_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_W'(5);
      index_bits  <= INDEX_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[OFFSET_W-1:0];
        REG_INDEX_BITS:  index_bits  <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [AW-1:0]        addr;
  logic [INDEX_W-1:0]   k_eff;
  logic [OFFSET_W:0]    tag_shift;
  logic [AW-1:0]        addr_off;
  logic [SW+AW-1:0]     addr_off_ext;
  logic [SW-1:0]        set_in;
  logic [TAG_W-1:0]     tag_in;

  always_comb begin
    addr         = address[AW-1:0];
    k_eff        = (index_bits > INDEX_W'(KMAX)) ? INDEX_W'(KMAX) : index_bits;
    addr_off     = addr >> offset_bits;
    addr_off_ext = (SW + AW)'(addr_off);
    set_in       = addr_off_ext[SW-1:0] & ~({SW{1'b1}} << k_eff);
    tag_shift    = {1'b0, offset_bits} + (OFFSET_W + 1)'(k_eff);
    tag_in       = addr >> tag_shift;
  end

  // control
  state_t         state, state_next;
  logic [SW-1:0]  clr_addr;
  logic [SW-1:0]  set_q;
  logic [TAG_W-1:0] tag_q;
  logic           accept;
  logic           done;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign done     = (state == ST_LOOKUP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == SW'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // set memory
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] wr_data;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  line_t [WAYS-1:0] rd_row;
  line_t [WAYS-1:0] new_row;

  assign mem_we    = (state == ST_CLEAR) || done;
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : set_q;
  assign wr_data   = (state == ST_CLEAR) ? '0 : ROW_W'(new_row);
  assign rd_row    = rd_data;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .ADDR_W(SW)
  ) u_set_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(set_in),
    .rdata(rd_data)
  );

  // lookup and replacement
  logic [WAYS-1:0] match_vec;
  logic            found;
  logic [WW-1:0]   hit_way;
  logic            have_inv;
  logic [WW-1:0]   inv_way;
  logic [WW-1:0]   lru_way;
  logic [WW-1:0]   sel_way;
  logic [RW:0]     old_rank;

  always_comb begin
    found    = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    lru_way  = '0;
    for (int i = 0; i < WAYS; i++) begin
      match_vec[i] = rd_row[i].valid && (rd_row[i].tag == tag_q);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found   = 1'b1;
        hit_way = WW'(i);
      end
      if (!rd_row[i].valid) begin
        have_inv = 1'b1;
        inv_way  = WW'(i);
      end
      // with every way valid the ranks are a permutation; LRU holds the top one
      if (rd_row[i].rank == RW'(WAYS - 1)) begin
        lru_way = WW'(i);
      end
    end

    priority if (found) begin
      sel_way  = hit_way;
      old_rank = {1'b0, rd_row[hit_way].rank};
    end else if (have_inv) begin
      sel_way  = inv_way;
      old_rank = (RW + 1)'(WAYS);
    end else begin
      sel_way  = lru_way;
      old_rank = {1'b0, rd_row[lru_way].rank};
    end

    for (int i = 0; i < WAYS; i++) begin
      new_row[i] = rd_row[i];
      if ((WW'(i) != sel_way) && rd_row[i].valid && ({1'b0, rd_row[i].rank} < old_rank)) begin
        new_row[i].rank = rd_row[i].rank + RW'(1);
      end
    end
    new_row[sel_way].rank = '0;
    if (!found) begin
      new_row[sel_way].valid = 1'b1;
      new_row[sel_way].tag   = tag_q;
    end
  end

  // result register and totals
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;
  logic [WW+1:0]     sel_way_ext;

  assign sel_way_ext = (WW + 2)'(sel_way);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
        if (found && (hit_count != '1)) begin
          hit_count <= hit_count + CNT_W'(1);
        end
        if (!found && (miss_count != '1)) begin
          miss_count <= miss_count + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit <= found;
      way <= sel_way_ext[1:0];
    end
  end

  assign hit_total  = hit_count;
  assign miss_total = miss_count;

  `ASSERT_CLK(a_accept_to_lookup, accept |=> (state == ST_LOOKUP), "accept did not start lookup")
  `ASSERT_CLK(a_tag_unique, (state == ST_LOOKUP) |-> $onehot0(match_vec), "tag present twice in a set")
  `ASSERT_CLK(a_one_total_moves, !$stable(hit_count) |-> $stable(miss_count), "both totals moved")
  `ASSERT_CLK(a_total_with_result, !$stable(miss_count) |-> out_valid, "total moved without a result")
  `ASSERT_NEVER(a_ready_in_clear, (state == ST_CLEAR) && in_ready, "input taken during clear")

endmodule

`default_nettype wire
